/* rtl/core/skvt_pkg.sv */
// shared constants and types for the sorted key/value table
package skvt_pkg;
    localparam int Capacity   = 64;
    localparam int ValueWidth = 32;
    localparam int KeyWidth   = 64;
    localparam int AddrWidth  = $clog2(Capacity);
    localparam int CountWidth = $clog2(Capacity + 1);

    localparam logic [2:0] ModeInsert = 3'd0;
    localparam logic [2:0] ModeRemove = 3'd1;
    localparam logic [2:0] ModeLookup = 3'd2;
    localparam logic [2:0] ModeSet    = 3'd3;
    localparam logic [2:0] ModeClear  = 3'd4;

    typedef struct packed {
        logic                  we;
        logic [AddrWidth-1:0]  waddr;
        logic [KeyWidth-1:0]   wkey;
        logic [ValueWidth-1:0] wval;
        logic                  wkey_en;
        logic [AddrWidth-1:0]  raddr;
    } t_mem_req;
endpackage

/* rtl/core/skvt_store.sv */
// key and value memories with one write and one registered read port
module skvt_store (
    input  logic                           i_clk,
    input  skvt_pkg::t_mem_req             i_req,
    output logic [skvt_pkg::KeyWidth-1:0]   o_rkey,
    output logic [skvt_pkg::ValueWidth-1:0] o_rval
);
    logic [skvt_pkg::KeyWidth-1:0]   r_keys [skvt_pkg::Capacity];
    logic [skvt_pkg::ValueWidth-1:0] r_vals [skvt_pkg::Capacity];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_vals[i_req.waddr] <= i_req.wval;
            if (i_req.wkey_en) begin
                r_keys[i_req.waddr] <= i_req.wkey;
            end
        end
        o_rkey <= r_keys[i_req.raddr];
        o_rval <= r_vals[i_req.raddr];
    end
endmodule

/* rtl/core/sorted_key_value_table.sv */
// top level of the sorted key/value table
// Sorted key/value table: up to 64 entries of a 64-bit key and a 32-bit value,
// kept in ascending key order, duplicates allowed. A request is taken when
// start is high and busy low; exactly one result comes back, shown for one
// cycle with o_done high, and it cannot be stalled. Timing is set by the single
// read port of the entry memory: each binary search probe takes an address step
// and then a registered data step, and an insert or remove then moves each
// shifted entry with a read step and then a write step; lookup and set finish
// right after the search, while clear, a full-table insert and a request that
// misses at once (empty table or key above the largest) finish straight from
// idle; an append into a non-full table needs no search. Memory contents are
// undefined after reset; only entries below the count are ever read.
module sorted_key_value_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_mode,
    input  logic [skvt_pkg::KeyWidth-1:0]   i_key,
    input  logic [skvt_pkg::ValueWidth-1:0] i_value,
    output logic                            o_done,
    output logic                            o_ok,
    output logic [skvt_pkg::ValueWidth-1:0] o_found_value,
    output logic [6:0]                      o_entry_count
);
    localparam int AW = skvt_pkg::AddrWidth;
    localparam int CW = skvt_pkg::CountWidth;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PROBE = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_SHRD  = 7'b0001000,
        S_SHWR  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_PREV  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [2:0]                      r_mode;
    logic [skvt_pkg::KeyWidth-1:0]   r_key;
    logic [skvt_pkg::ValueWidth-1:0] r_val;
    logic [CW-1:0]                   r_count, n_count;
    logic [skvt_pkg::KeyWidth-1:0]   r_largest, n_largest;
    logic [CW-1:0]                   r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]                   r_idx, n_idx;   // target slot
    logic [CW-1:0]                   r_ptr, n_ptr;   // shift pointer
    logic                            r_hit, n_hit;
    logic                            r_fix, n_fix;   // largest key removed
    logic [skvt_pkg::ValueWidth-1:0] r_fv, n_fv;
    logic                            n_done, n_ok;
    logic [skvt_pkg::ValueWidth-1:0] n_out_fv;
    logic [CW-1:0]                   mid;
    skvt_pkg::t_mem_req              mem;
    logic [skvt_pkg::KeyWidth-1:0]   rkey;
    logic [skvt_pkg::ValueWidth-1:0] rval;

    skvt_store u_store (.i_clk(i_clk), .i_req(mem), .o_rkey(rkey), .o_rval(rval));

    assign busy = (r_state != S_IDLE);
    assign mid  = CW'((r_lo + r_hi) >> 1);

    always_comb begin
        n_state = r_state; n_count = r_count; n_largest = r_largest;
        n_lo = r_lo; n_hi = r_hi; n_idx = r_idx; n_ptr = r_ptr; n_hit = r_hit;
        n_fix = r_fix; n_fv = r_fv;
        n_done = 1'b0; n_ok = 1'b0; n_out_fv = '0;
        mem = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_lo = '0; n_hi = r_count; n_hit = 1'b0; n_fv = '0; n_fix = 1'b0;
                    unique case (i_mode) inside
                        skvt_pkg::ModeInsert: begin
                            if (r_count >= CW'(skvt_pkg::Capacity)) begin
                                n_done = 1'b1;
                                n_state = S_IDLE;
                            end else if (r_count == '0 || i_key > r_largest) begin
                                n_idx = r_count; n_ptr = r_count; n_state = S_FIN;
                            end else begin
                                n_state = S_PROBE;
                            end
                        end
                        skvt_pkg::ModeRemove, skvt_pkg::ModeLookup,
                        skvt_pkg::ModeSet: begin
                            if (r_count == '0 || i_key > r_largest) begin
                                n_done = 1'b1;
                            end else begin
                                n_state = S_PROBE;
                            end
                        end
                        skvt_pkg::ModeClear: begin
                            n_count = '0; n_largest = '0; n_done = 1'b1; n_ok = 1'b1;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi && !r_hit) begin
                    mem.raddr = AW'(mid);
                    n_idx = mid;
                    n_state = S_CHECK;
                end else if (r_mode == skvt_pkg::ModeInsert) begin
                    n_idx = r_lo; n_ptr = r_count; n_state = S_SHRD;
                end else if (!r_hit) begin
                    n_done = 1'b1; n_state = S_IDLE;
                end else if (r_mode == skvt_pkg::ModeLookup) begin
                    n_done = 1'b1; n_ok = 1'b1; n_out_fv = r_fv; n_state = S_IDLE;
                end else if (r_mode == skvt_pkg::ModeSet) begin
                    mem.we = 1'b1; mem.waddr = AW'(r_idx); mem.wval = r_val;
                    n_done = 1'b1; n_ok = 1'b1; n_state = S_IDLE;
                end else begin
                    // remove: largest fix needs the key below the slot
                    n_fix = (r_key == r_largest);
                    n_ptr = r_idx;
                    if (r_key == r_largest && r_idx != '0) begin
                        mem.raddr = AW'(r_idx - 1'b1);
                        n_state = S_PREV;
                    end else begin
                        if (r_key == r_largest) n_largest = '0;
                        n_state = S_SHRD;
                    end
                end
            end
            S_PREV: begin
                n_largest = rkey;
                n_state = S_SHRD;
            end
            S_CHECK: begin
                if (r_mode == skvt_pkg::ModeInsert) begin
                    if (rkey < r_key) n_lo = r_idx + 1'b1; else n_hi = r_idx;
                end else if (rkey == r_key) begin
                    n_hit = 1'b1; n_fv = rval;
                end else if (rkey < r_key) begin
                    n_lo = r_idx + 1'b1;
                end else begin
                    n_hi = r_idx;
                end
                n_state = S_PROBE;
            end
            S_SHRD: begin
                // insert moves ptr-1 to ptr down to idx; remove moves ptr+1 to ptr
                if (r_mode == skvt_pkg::ModeInsert) begin
                    if (r_ptr > r_idx) begin
                        mem.raddr = AW'(r_ptr - 1'b1); n_state = S_SHWR;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    if (CW'(r_ptr + 1'b1) < r_count) begin
                        mem.raddr = AW'(r_ptr + 1'b1); n_state = S_SHWR;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SHWR: begin
                mem.we = 1'b1; mem.wkey_en = 1'b1; mem.waddr = AW'(r_ptr);
                mem.wkey = rkey; mem.wval = rval;
                n_ptr = (r_mode == skvt_pkg::ModeInsert) ? r_ptr - 1'b1 : r_ptr + 1'b1;
                n_state = S_SHRD;
            end
            S_FIN: begin
                n_done = 1'b1; n_ok = 1'b1; n_state = S_IDLE;
                if (r_mode == skvt_pkg::ModeInsert) begin
                    mem.we = 1'b1; mem.wkey_en = 1'b1; mem.waddr = AW'(r_idx);
                    mem.wkey = r_key; mem.wval = r_val;
                    n_count = r_count + 1'b1;
                    if (r_key > r_largest) n_largest = r_key;
                end else begin
                    n_count = r_count - 1'b1; n_out_fv = r_fv;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_largest <= '0; o_done <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_largest <= n_largest;
            o_done <= n_done;
        end
        if (r_state == S_IDLE && start) begin
            r_mode <= i_mode; r_key <= i_key; r_val <= i_value;
        end
        r_lo <= n_lo; r_hi <= n_hi; r_idx <= n_idx; r_ptr <= n_ptr;
        r_hit <= n_hit; r_fix <= n_fix; r_fv <= n_fv;
        o_ok <= n_ok; o_found_value <= n_out_fv;
        o_entry_count <= 7'(n_count);
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(skvt_pkg::Capacity)) else $error("count above capacity");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("beat while busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && !$past(busy)) |-> !o_done) else $error("beat on entry");
    a_fix_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREV) |-> r_fix) else $error("prev read without fix");
`endif
endmodule
